@@ rtl/core/ric_pkg.sv @@
// shared constants and types for the rgb image convolution block
`timescale 1ns / 1ps
`default_nettype none
package ric_pkg;
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int MAX_KERNEL_DEF = 7;
   localparam int FRAC_BITS = 12;
   localparam int COEF_W = 18;
   localparam int PIX_W = 8;
   localparam int NUM_LANES = 3;
   // 8-bit pixel times 18-bit coefficient, accumulator room for up to 256 taps
   localparam int PROD_W = PIX_W + COEF_W + 1;
   localparam int ACC_W = PROD_W + 8;

   typedef enum logic [1:0] {
      ACT_COEF = 2'd0,
      ACT_PIXEL = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KSIZE  = 2'd2;
   localparam logic [1:0] REG_ALPHA  = 2'd3;

   // lane control from the sequencer
   typedef struct packed {
      logic clear;
      logic tap;
   } lane_ctl_type;
endpackage
`default_nettype wire

@@ rtl/core/ric_lane.sv @@
// one color channel multiply-accumulate lane with clamp and truncate
`timescale 1ns / 1ps
`default_nettype none
module ric_lane (
   input  wire logic                               clock,
   input  wire ric_pkg::lane_ctl_type              ctl,
   input  wire logic [ric_pkg::PIX_W-1:0]          pixel,
   input  wire logic signed [ric_pkg::COEF_W-1:0]  coef,
   output logic [ric_pkg::PIX_W-1:0]               result
);
   import ric_pkg::*;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;

   always_comb begin
      prod_in = PROD_W'($signed({1'b0, pixel}) * coef);
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.tap) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      shifted = acc_ff >>> FRAC_BITS;
      if (acc_ff <= 0) begin
         result = '0;
      end else if (shifted > ACC_W'(255)) begin
         result = 8'hff;
      end else begin
         result = shifted[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end
endmodule
`default_nettype wire

@@ rtl/core/rgb_image_convolution_top.sv @@
// top level: stores, tap sequencer, three channel lanes and output register
// a write is stored at its transfer; a compute result passes the tap, drain and output states
// throughput: one item at a time; a write frees the input the next cycle
// a compute holds the input through the tap, drain and output states, one tap per cycle
// a waiting result only holds the end of the next compute; writes still pass
// reset: synchronous active high; registers to defaults, stores undefined until written
`timescale 1ns / 1ps
`default_nettype none
module rgb_image_convolution_top #(
   parameter int MAX_WIDTH  = ric_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ric_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_KERNEL = ric_pkg::MAX_KERNEL_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [5:0]  req_x_pos,
   input  wire logic [5:0]  req_y_pos,
   input  wire logic [5:0]  req_coef_index,
   input  wire logic signed [17:0] req_coef_value,
   input  wire logic [7:0]  req_in_red,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_blue,
   input  wire logic [7:0]  req_in_alpha,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_out_x,
   output logic [5:0]       rsp_out_y,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_alpha,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ric_pkg::*;
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int IAW = $clog2(IMG_DEPTH) > 0 ? $clog2(IMG_DEPTH) : 1;
   localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int CAW = $clog2(COEF_DEPTH) > 0 ? $clog2(COEF_DEPTH) : 1;
   localparam int KW = $clog2(MAX_KERNEL + 1);
   // signed coordinate width covering 6-bit request plus offsets
   localparam int SW = ((XW > YW) ? XW : YW) + 8;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TAP, ST_DRAIN1, ST_DRAIN2, ST_DRAIN3, ST_OUT
   } state_type;

   logic [31:0] image_mem [IMG_DEPTH];
   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];

   state_type state_ff;
   logic [6:0] width_ff, height_ff;
   logic [2:0] ksize_ff;
   logic alpha_en_ff;
   logic [5:0] x_ff, y_ff;
   logic [KW-1:0] kk_ff, half_ff, ti_ff, tj_ff;
   logic [CAW-1:0] cidx_ff;
   logic [SW-1:0] wmax_ff, hmax_ff;
   logic [1:0] tapv_ff;     // tap valid: memory read stage, multiply stage
   logic [31:0] pix_ff;
   logic signed [COEF_W-1:0] coef_ff;
   logic [7:0] alpha_ff;
   logic rsp_valid_ff;
   logic [5:0] rsp_x_ff, rsp_y_ff;
   logic [7:0] red_ff, green_ff, blue_ff, rsp_alpha_ff;
   logic [7:0] lane_res [NUM_LANES];
   lane_ctl_type ctl;
   logic [IAW-1:0] raddr;
   logic last_tap, req_fire, wr_en, out_load;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         REG_WIDTH:  prdata = {25'd0, width_ff};
         REG_HEIGHT: prdata = {25'd0, height_ff};
         REG_KSIZE:  prdata = {29'd0, ksize_ff};
         REG_ALPHA:  prdata = {31'd0, alpha_en_ff};
         default:    prdata = '0;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   // in the output state, the output register loads when empty or emptied in the same cycle
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // effective geometry from the registers
   logic [SW-1:0] w_eff, h_eff;
   logic [KW-1:0] k_eff;
   always_comb begin
      w_eff = SW'(width_ff);
      if (width_ff == 7'd0) w_eff = SW'(1);
      if (w_eff > SW'(MAX_WIDTH)) w_eff = SW'(MAX_WIDTH);
      h_eff = SW'(height_ff);
      if (height_ff == 7'd0) h_eff = SW'(1);
      if (h_eff > SW'(MAX_HEIGHT)) h_eff = SW'(MAX_HEIGHT);
      k_eff = (KW'(ksize_ff) > KW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(ksize_ff);
   end

   // neighbor address for the current tap
   logic signed [SW-1:0] nx, ny;
   logic [SW-1:0] cx, cy;
   always_comb begin
      nx = $signed(SW'(x_ff)) + $signed(SW'(ti_ff)) - $signed(SW'(half_ff));
      ny = $signed(SW'(y_ff)) + $signed(SW'(tj_ff)) - $signed(SW'(half_ff));
      if (nx < 0) cx = '0;
      else if (nx > $signed(wmax_ff)) cx = wmax_ff;
      else cx = nx;
      if (ny < 0) cy = '0;
      else if (ny > $signed(hmax_ff)) cy = hmax_ff;
      else cy = ny;
      raddr = IAW'(cy * SW'(MAX_WIDTH) + cx);
      last_tap = (ti_ff == kk_ff - KW'(1)) && (tj_ff == kk_ff - KW'(1));
   end

   assign ctl.clear = req_fire;
   assign ctl.tap = tapv_ff[1];

   always_ff @(posedge clock) begin
      if (req_fire && req_action == ACT_COEF && 8'(req_coef_index) < 8'(COEF_DEPTH)) begin
         coef_mem[CAW'(req_coef_index)] <= req_coef_value;
      end
      if (req_fire && req_action == ACT_PIXEL
          && 13'(req_x_pos) < 13'(MAX_WIDTH) && 13'(req_y_pos) < 13'(MAX_HEIGHT)) begin
         image_mem[IAW'(req_y_pos) * IAW'(MAX_WIDTH) + IAW'(req_x_pos)] <=
            {req_in_alpha, req_in_blue, req_in_green, req_in_red};
      end
      pix_ff <= image_mem[raddr];
      coef_ff <= coef_mem[cidx_ff];
   end

   generate
      for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
         ric_lane u_lane (
            .clock(clock), .ctl(ctl), .pixel(pix_ff[8*g +: 8]),
            .coef(coef_ff), .result(lane_res[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= 7'd64;
         height_ff <= 7'd64;
         ksize_ff <= 3'd3;
         alpha_en_ff <= 1'b0;
         tapv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            unique case (paddr[3:2])
               REG_WIDTH:  width_ff <= pwdata[6:0];
               REG_HEIGHT: height_ff <= pwdata[6:0];
               REG_KSIZE:  ksize_ff <= pwdata[2:0];
               REG_ALPHA:  alpha_en_ff <= pwdata[0];
               default: ;
            endcase
         end
         tapv_ff <= {tapv_ff[0], state_ff == ST_TAP};
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_action == ACT_COMPUTE) begin
                  x_ff <= req_x_pos;
                  y_ff <= req_y_pos;
                  kk_ff <= k_eff;
                  half_ff <= k_eff >> 1;
                  ti_ff <= '0;
                  tj_ff <= '0;
                  cidx_ff <= '0;
                  wmax_ff <= w_eff - SW'(1);
                  hmax_ff <= h_eff - SW'(1);
                  state_ff <= (k_eff == '0) ? ST_DRAIN1 : ST_TAP;
               end
            end
            ST_TAP: begin
               if (last_tap) begin
                  // center pixel read next for alpha
                  ti_ff <= half_ff;
                  tj_ff <= half_ff;
                  state_ff <= ST_DRAIN1;
               end else if (ti_ff == kk_ff - KW'(1)) begin
                  ti_ff <= '0;
                  tj_ff <= tj_ff + KW'(1);
               end else begin
                  ti_ff <= ti_ff + KW'(1);
               end
               cidx_ff <= cidx_ff + CAW'(1);
            end
            ST_DRAIN1: begin
               ti_ff <= half_ff;
               tj_ff <= half_ff;
               state_ff <= ST_DRAIN2;
            end
            ST_DRAIN2: state_ff <= ST_DRAIN3;
            ST_DRAIN3: begin
               alpha_ff <= pix_ff[31:24];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold here while the previous result still waits
               if (out_load) begin
                  red_ff <= (kk_ff == '0) ? 8'd0 : lane_res[0];
                  green_ff <= (kk_ff == '0) ? 8'd0 : lane_res[1];
                  blue_ff <= (kk_ff == '0) ? 8'd0 : lane_res[2];
                  rsp_alpha_ff <= alpha_en_ff ? alpha_ff : 8'd0;
                  rsp_x_ff <= x_ff;
                  rsp_y_ff <= y_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_red = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue = blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("accepted while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray result");
   a_tap_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> !tapv_ff[0]) else $error("tap outside compute");
endmodule
`default_nettype wire

@@ tb/rgb_image_convolution_top_test.sv @@
// self-checking testbench for the rgb image convolution block
`timescale 1ns / 1ps
module rgb_image_convolution_top_test;
   import ric_pkg::*;

   typedef struct {
      action_type         act;
      logic [5:0]         x;
      logic [5:0]         y;
      logic [5:0]         cidx;
      logic signed [17:0] cval;
      logic [7:0]         r, g, b, a;
   } req_item_type;

   typedef struct {
      logic [5:0] x, y;
      logic [7:0] r, g, b, a;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = '0;
   logic [5:0] req_x_pos = '0, req_y_pos = '0, req_coef_index = '0;
   logic signed [17:0] req_coef_value = '0;
   logic [7:0] req_in_red = '0, req_in_green = '0, req_in_blue = '0, req_in_alpha = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_out_x, rsp_out_y;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   rgb_image_convolution_top i_dut (.*);

   always #5 clock = ~clock;

   // shadow state of the block
   logic [31:0]        img_mem [4096];
   logic signed [17:0] kern_mem [49];
   logic [6:0] cfg_width = 7'd64, cfg_height = 7'd64;
   logic [2:0] cfg_ksize = 3'd3;
   logic       cfg_alpha = 1'b0;

   req_item_type     pending_q [$];
   pixel_result_type filtered_q [$];
   int err_count = 0;

   function automatic logic [7:0] clamp_channel(longint s);
      longint q;
      if (s <= 0) return 8'd0;
      q = s >>> FRAC_BITS;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic int clamp_int(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int used_width();
      return (cfg_width < 1) ? 1 : (cfg_width > 64) ? 64 : int'(cfg_width);
   endfunction

   function automatic int used_height();
      return (cfg_height < 1) ? 1 : (cfg_height > 64) ? 64 : int'(cfg_height);
   endfunction

   task automatic apply_item(req_item_type it);
      int w, h, k, half, dx, dy;
      longint sr, sg, sb, c;
      logic [31:0] px;
      pixel_result_type res;
      sr = 0; sg = 0; sb = 0;
      case (it.act)
         ACT_COEF: if (it.cidx < 49) kern_mem[it.cidx] = it.cval;
         ACT_PIXEL: img_mem[{it.y, it.x}] = {it.a, it.b, it.g, it.r};
         ACT_COMPUTE: begin
            w = used_width();
            h = used_height();
            k = int'(cfg_ksize);
            half = k / 2;
            for (int j = 0; j < k; j++) begin
               for (int i = 0; i < k; i++) begin
                  dx = clamp_int(int'(it.x) + i - half, w - 1);
                  dy = clamp_int(int'(it.y) + j - half, h - 1);
                  px = img_mem[dy * 64 + dx];
                  c = longint'(kern_mem[j * k + i]);
                  sr += longint'(px[7:0]) * c;
                  sg += longint'(px[15:8]) * c;
                  sb += longint'(px[23:16]) * c;
               end
            end
            res.x = it.x;
            res.y = it.y;
            res.r = clamp_channel(sr);
            res.g = clamp_channel(sg);
            res.b = clamp_channel(sb);
            px = img_mem[clamp_int(int'(it.y), h - 1) * 64 + clamp_int(int'(it.x), w - 1)];
            res.a = cfg_alpha ? px[31:24] : 8'd0;
            filtered_q.push_back(res);
         end
         default: ;
      endcase
   endtask

   // driver: bursts of transfers with random gaps
   req_item_type cur_item;
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_item(cur_item);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               cur_item = pending_q.pop_front();
               req_valid <= 1'b1;
               req_action <= cur_item.act;
               req_x_pos <= cur_item.x;
               req_y_pos <= cur_item.y;
               req_coef_index <= cur_item.cidx;
               req_coef_value <= cur_item.cval;
               req_in_red <= cur_item.r;
               req_in_green <= cur_item.g;
               req_in_blue <= cur_item.b;
               req_in_alpha <= cur_item.a;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: receiver stall pattern rotates through always ready, random and sparse ready
   int cyc = 0;
   always @(posedge clock) begin
      pixel_result_type e;
      cyc++;
      case ((cyc / 400) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= (cyc % 5 == 0);
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_out_x, rsp_out_y);
            err_count++;
         end else begin
            e = filtered_q.pop_front();
            if ({rsp_out_x, rsp_out_y, rsp_out_red, rsp_out_green, rsp_out_blue,
                 rsp_out_alpha} !== {e.x, e.y, e.r, e.g, e.b, e.a}) begin
               $display("%0t: mismatch expected x=%0d y=%0d rgba=%0d,%0d,%0d,%0d",
                        $time, e.x, e.y, e.r, e.g, e.b, e.a);
               $display("%0t:          actual   x=%0d y=%0d rgba=%0d,%0d,%0d,%0d",
                        $time, rsp_out_x, rsp_out_y, rsp_out_red, rsp_out_green,
                        rsp_out_blue, rsp_out_alpha);
               err_count++;
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_WIDTH: cfg_width = val[6:0];
         REG_HEIGHT: cfg_height = val[6:0];
         REG_KSIZE: cfg_ksize = val[2:0];
         default: cfg_alpha = val[0];
      endcase
   endtask

   // look after the clock edge so driver updates have settled
   task automatic wait_idle();
      while (pending_q.size() > 0 || req_valid || filtered_q.size() > 0) begin
         @(posedge clock);
         #1;
      end
      repeat (60) @(posedge clock);
   endtask

   function automatic req_item_type mk_item(action_type act, int x, int y);
      req_item_type it;
      it.act = act;
      it.x = 6'(x);
      it.y = 6'(y);
      it.cidx = 6'($urandom_range(0, 63));
      it.cval = 18'($urandom);
      it.r = 8'($urandom);
      it.g = 8'($urandom);
      it.b = 8'($urandom);
      it.a = 8'($urandom);
      return it;
   endfunction

   function automatic void push_coef(int idx, int val);
      req_item_type it;
      it = mk_item(ACT_COEF, $urandom_range(0, 63), $urandom_range(0, 63));
      it.cidx = 6'(idx);
      it.cval = 18'(val);
      pending_q.push_back(it);
   endfunction

   function automatic void push_pixel(int x, int y, logic [7:0] v);
      req_item_type it;
      it = mk_item(ACT_PIXEL, x, y);
      if (v != 8'd1) {it.r, it.g, it.b, it.a} = {4{v}};
      pending_q.push_back(it);
   endfunction

   function automatic int small_coef();
      return ($urandom_range(0, 7) == 0) ? int'($signed(18'($urandom)))
                                         : $urandom_range(0, 6000) - 1500;
   endfunction

   int phase_cfg [8][4] = '{
      '{4, 4, 3, 1}, '{64, 2, 7, 1}, '{1, 64, 1, 0}, '{0, 0, 0, 1},
      '{127, 1, 7, 0}, '{8, 8, 5, 1}, '{3, 5, 2, 0}, '{16, 8, 6, 1}};

   initial begin
      req_item_type it;
      int w, h, sel;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         csr_write(REG_WIDTH, phase_cfg[p][0]);
         csr_write(REG_HEIGHT, phase_cfg[p][1]);
         csr_write(REG_KSIZE, phase_cfg[p][2]);
         csr_write(REG_ALPHA, phase_cfg[p][3]);
         w = used_width();
         h = used_height();
         // every tap read later must see a written entry
         if (p == 0) for (int i = 0; i < 49; i++) push_coef(i, small_coef());
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) push_pixel(x, y, 8'd1);
         if (p == 0) begin
            push_coef(4, 131071);
            push_coef(63, -5);
            push_coef(49, 7);
            push_pixel(0, 0, 8'd255);
            push_pixel(3, 3, 8'd0);
            pending_q.push_back(mk_item(ACT_COMPUTE, 0, 0));
            pending_q.push_back(mk_item(ACT_COMPUTE, 3, 3));
            pending_q.push_back(mk_item(ACT_COMPUTE, 63, 63));
            push_coef(4, -131072);
            pending_q.push_back(mk_item(ACT_COMPUTE, 1, 1));
            pending_q.push_back(mk_item(ACT_NONE, 2, 2));
            push_coef(4, 4096);
            push_coef(48, -1);
            pending_q.push_back(mk_item(ACT_COMPUTE, 0, 63));
            pending_q.push_back(mk_item(ACT_COMPUTE, 63, 0));
            pending_q.push_back(mk_item(ACT_PIXEL, 63, 63));
         end
         for (int n = 0; n < 175; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
               it = mk_item(ACT_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63));
               if (sel < 25) begin
                  it.x = 6'($urandom_range(0, w - 1));
                  it.y = 6'($urandom_range(0, h - 1));
               end
            end else if (sel < 70) begin
               it = mk_item(ACT_PIXEL, $urandom_range(0, 63), $urandom_range(0, 63));
            end else if (sel < 95) begin
               it = mk_item(ACT_COEF, 0, 0);
               it.x = 6'($urandom);
               it.y = 6'($urandom);
               if (sel < 90) it.cval = 18'(small_coef());
            end else begin
               it = mk_item(ACT_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
            end
            pending_q.push_back(it);
         end
      end
      wait_idle();
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/ric_pkg.sv
rtl/core/ric_lane.sv
rtl/core/rgb_image_convolution_top.sv
tb/rgb_image_convolution_top_test.sv
